// File: design/mr_round_pkg.sv
// Package with the microcode format and program of the Miller-Rabin round sequencer.
package mr_round_pkg;

  typedef logic [4:0] upc_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_SETUP,
    OP_STRIP,
    OP_MUL_RED,
    OP_MUL_ACC,
    OP_MUL_SQ,
    OP_MUL_CUR,
    OP_WAIT_SQ,
    OP_WAIT_ACC,
    OP_ACC_ONE,
    OP_SHIFT_E,
    OP_SET_PREV,
    OP_ROOT,
    OP_FINAL,
    OP_EMIT
  } op_e;

  typedef enum logic [3:0] {
    C_NEXT,
    C_ALWAYS,
    C_NO_INPUT,
    C_TRIVIAL,
    C_E_EVEN,
    C_E_ZERO,
    C_MUL_BUSY,
    C_T_ZERO,
    C_BAD_ROOT,
    C_OUT_FREE
  } cond_e;

  typedef struct packed {
    op_e   op;
    cond_e cond;
    upc_t  target;
  } ucode_t;

  localparam upc_t U_IDLE     = 5'd0;
  localparam upc_t U_SETUP    = 5'd1;
  localparam upc_t U_STRIP    = 5'd2;
  localparam upc_t U_RED      = 5'd3;
  localparam upc_t U_RED_WAIT = 5'd4;
  localparam upc_t U_ACC_ONE  = 5'd5;
  localparam upc_t U_POW_HEAD = 5'd6;
  localparam upc_t U_POW_BIT  = 5'd7;
  localparam upc_t U_MUL_ACC  = 5'd8;
  localparam upc_t U_ACC_WAIT = 5'd9;
  localparam upc_t U_MUL_SQ   = 5'd10;
  localparam upc_t U_SQ_WAIT  = 5'd11;
  localparam upc_t U_SHIFT    = 5'd12;
  localparam upc_t U_SQUARES  = 5'd13;
  localparam upc_t U_SQR_HEAD = 5'd14;
  localparam upc_t U_MUL_CUR  = 5'd15;
  localparam upc_t U_CUR_WAIT = 5'd16;
  localparam upc_t U_ROOT     = 5'd17;
  localparam upc_t U_SQR_LOOP = 5'd18;
  localparam upc_t U_FINAL    = 5'd19;
  localparam upc_t U_EMIT     = 5'd20;
  localparam upc_t U_EMIT_HLD = 5'd21;

  function automatic ucode_t ucode_rom(input upc_t pc);
    ucode_t w;
    unique case (pc)
      U_IDLE:     w = '{OP_LOAD,     C_NO_INPUT, U_IDLE};
      U_SETUP:    w = '{OP_SETUP,    C_TRIVIAL,  U_EMIT};
      U_STRIP:    w = '{OP_STRIP,    C_E_EVEN,   U_STRIP};
      U_RED:      w = '{OP_MUL_RED,  C_NEXT,     U_IDLE};
      U_RED_WAIT: w = '{OP_WAIT_SQ,  C_MUL_BUSY, U_RED_WAIT};
      U_ACC_ONE:  w = '{OP_ACC_ONE,  C_NEXT,     U_IDLE};
      U_POW_HEAD: w = '{OP_NOP,      C_E_ZERO,   U_SQUARES};
      U_POW_BIT:  w = '{OP_NOP,      C_E_EVEN,   U_MUL_SQ};
      U_MUL_ACC:  w = '{OP_MUL_ACC,  C_NEXT,     U_IDLE};
      U_ACC_WAIT: w = '{OP_WAIT_ACC, C_MUL_BUSY, U_ACC_WAIT};
      U_MUL_SQ:   w = '{OP_MUL_SQ,   C_NEXT,     U_IDLE};
      U_SQ_WAIT:  w = '{OP_WAIT_SQ,  C_MUL_BUSY, U_SQ_WAIT};
      U_SHIFT:    w = '{OP_SHIFT_E,  C_ALWAYS,   U_POW_HEAD};
      U_SQUARES:  w = '{OP_SET_PREV, C_NEXT,     U_IDLE};
      U_SQR_HEAD: w = '{OP_NOP,      C_T_ZERO,   U_FINAL};
      U_MUL_CUR:  w = '{OP_MUL_CUR,  C_NEXT,     U_IDLE};
      U_CUR_WAIT: w = '{OP_WAIT_ACC, C_MUL_BUSY, U_CUR_WAIT};
      U_ROOT:     w = '{OP_ROOT,     C_BAD_ROOT, U_EMIT};
      U_SQR_LOOP: w = '{OP_NOP,      C_ALWAYS,   U_SQR_HEAD};
      U_FINAL:    w = '{OP_FINAL,    C_NEXT,     U_IDLE};
      U_EMIT:     w = '{OP_EMIT,     C_OUT_FREE, U_IDLE};
      U_EMIT_HLD: w = '{OP_NOP,      C_ALWAYS,   U_EMIT};
      default:    w = '{OP_NOP,      C_ALWAYS,   U_IDLE};
    endcase
    return w;
  endfunction

endpackage

// File: design/miller_rabin_round.sv
// Top level of the microcoded Miller-Rabin round for one candidate and one base.
//
// Usage: present candidate_i and base_i with in_valid_i; the transaction is taken
// at a clock edge where in_valid_i is high and in_stall_o is low. One result
// transaction follows on out_valid_o with probable_prime_o and base_used_o, and
// it is taken at an edge where out_valid_o is high and out_stall_i is low.
// The block works on one transaction at a time; in_stall_o is low only while the
// sequencer waits in its idle step, which it reenters as soon as the result sits
// in the output register, even if the receiver still stalls it.
// Run time: for trivial candidates (below two or even) the setup step hands
// the result straight to the emit step. Otherwise the shared shift-add modular
// multiplier sets the run time; it forms one product at a time, and a round
// needs at most 2*WIDTH products.
// Reset returns the sequencer to its idle step and empties the output register.
// While the receiver stalls a waiting result, a finished next result holds in
// the emit step until the output register frees.
module miller_rabin_round #(
  parameter int WIDTH = 63
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [62:0] candidate_i,
  input  logic [62:0] base_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        probable_prime_o,
  output logic        base_used_o
);
  import mr_round_pkg::*;

  localparam int TW = $clog2(WIDTH);

  upc_t           upc_q, upc_d;
  ucode_t         uw;
  logic           jump;
  logic [WIDTH-1:0] n_q, e_q, acc_q, sq_q, prev_q, mx_q, my_q, mp_q;
  logic [TW-1:0]  t_q;
  logic           ver_q, used_q;
  logic           out_valid_q, out_prime_q, out_used_q;
  logic           accept, out_free, trivial, bad_root, mul_busy;
  logic [WIDTH-1:0] n_m1;
  logic [WIDTH:0] add_s, dbl_s;
  logic [WIDTH-1:0] add_r, dbl_r;

  assign uw       = ucode_rom(upc_q);
  assign accept   = in_valid_i && (upc_q == U_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;
  assign n_m1     = n_q - WIDTH'(1);
  assign trivial  = !n_q[0] || (n_q[WIDTH-1:1] == '0);
  assign bad_root = (acc_q == WIDTH'(1)) && (prev_q != WIDTH'(1)) && (prev_q != n_m1);
  assign mul_busy = (my_q != '0);

  assign add_s = {1'b0, mp_q} + {1'b0, mx_q};
  assign add_r = (add_s >= {1'b0, n_q}) ? WIDTH'(add_s - {1'b0, n_q}) : add_s[WIDTH-1:0];
  assign dbl_s = {mx_q, 1'b0};
  assign dbl_r = (dbl_s >= {1'b0, n_q}) ? WIDTH'(dbl_s - {1'b0, n_q}) : dbl_s[WIDTH-1:0];

  always_comb begin
    unique case (uw.cond)
      C_NEXT:     jump = 1'b0;
      C_ALWAYS:   jump = 1'b1;
      C_NO_INPUT: jump = !in_valid_i;
      C_TRIVIAL:  jump = trivial;
      C_E_EVEN:   jump = !e_q[0];
      C_E_ZERO:   jump = (e_q == '0);
      C_MUL_BUSY: jump = mul_busy;
      C_T_ZERO:   jump = (t_q == '0);
      C_BAD_ROOT: jump = bad_root;
      C_OUT_FREE: jump = out_free;
      default:    jump = 1'b1;
    endcase
  end

  always_comb begin
    upc_d = jump ? uw.target : upc_t'(upc_q + 5'd1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q       <= U_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      upc_q <= upc_d;
      if (uw.op == OP_EMIT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (uw.op)
      OP_LOAD: begin
        if (accept) begin
          n_q  <= candidate_i[WIDTH-1:0];
          sq_q <= base_i[WIDTH-1:0];
        end
      end
      OP_SETUP: begin
        e_q    <= n_m1;
        t_q    <= '0;
        ver_q  <= (n_q == WIDTH'(2));
        used_q <= 1'b0;
      end
      OP_STRIP: begin
        if (!e_q[0]) begin
          e_q <= e_q >> 1;
          t_q <= t_q + TW'(1);
        end
      end
      OP_MUL_RED: begin
        mx_q <= WIDTH'(1);
        my_q <= sq_q;
        mp_q <= '0;
      end
      OP_MUL_ACC: begin
        mx_q <= sq_q;
        my_q <= acc_q;
        mp_q <= '0;
      end
      OP_MUL_SQ: begin
        mx_q <= sq_q;
        my_q <= sq_q;
        mp_q <= '0;
      end
      OP_MUL_CUR: begin
        mx_q <= acc_q;
        my_q <= acc_q;
        mp_q <= '0;
      end
      OP_WAIT_SQ, OP_WAIT_ACC: begin
        if (mul_busy) begin
          if (my_q[0]) begin
            mp_q <= add_r;
          end
          mx_q <= dbl_r;
          my_q <= my_q >> 1;
        end else if (uw.op == OP_WAIT_SQ) begin
          sq_q <= mp_q;
        end else begin
          acc_q <= mp_q;
        end
      end
      OP_ACC_ONE:  acc_q <= WIDTH'(1);
      OP_SHIFT_E:  e_q <= e_q >> 1;
      OP_SET_PREV: prev_q <= acc_q;
      OP_ROOT: begin
        t_q    <= t_q - TW'(1);
        prev_q <= acc_q;
        ver_q  <= 1'b0;
        used_q <= 1'b1;
      end
      OP_FINAL: begin
        ver_q  <= (acc_q == WIDTH'(1));
        used_q <= 1'b1;
      end
      OP_EMIT: begin
        if (out_free) begin
          out_prime_q <= ver_q;
          out_used_q  <= used_q;
        end
      end
      default: begin
      end
    endcase
  end

  assign in_stall_o       = (upc_q != U_IDLE);
  assign out_valid_o      = out_valid_q;
  assign probable_prime_o = out_prime_q;
  assign base_used_o      = out_used_q;

`ifndef SYNTHESIS
  a_mul_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (uw.op == OP_WAIT_SQ || uw.op == OP_WAIT_ACC) |-> (mp_q < n_q) && (mx_q < n_q))
    else $error("modular multiplier operand left its range");

  a_emit_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(upc_q == U_EMIT))
    else $error("result appeared outside the emit step");

  a_accept_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (upc_q == U_SETUP))
    else $error("sequencer did not start after a transaction");

  a_pow_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upc_q == U_POW_HEAD) |-> (acc_q < n_q) && (sq_q < n_q))
    else $error("power registers not reduced");
`endif

endmodule

// File: tb/testbench.sv
// Self-checking testbench for the Miller-Rabin round with randomized handshakes.
module testbench;

  localparam int          LIMIT_CYCLES = 4000000;
  localparam int          HOLD_CYCLES  = 300;
  localparam logic [62:0] ALL_ONES     = 63'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [62:0] MERSENNE_61  = 63'd2305843009213693951;
  localparam logic [62:0] TOP_PRIME    = 63'd9223372036854775783;
  localparam logic [62:0] FERMAT_16    = 63'd65537;

  typedef struct {
    logic        prime;
    logic        via_base;
    logic [62:0] cand;
    logic [62:0] base;
  } verdict_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid;
  logic        in_stall_o;
  logic [62:0] cand_d;
  logic [62:0] base_d;
  logic        out_valid_o;
  logic        out_stall = 1'b0;
  logic        probable_prime_o;
  logic        base_used_o;

  verdict_t    pending_verdicts[$];
  int          mismatch_count = 0;
  int          cycle_count = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  bit          hold_req = 1'b0;
  int          hold_count = 0;

  miller_rabin_round dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall_o),
    .candidate_i      (cand_d),
    .base_i           (base_d),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall),
    .probable_prime_o (probable_prime_o),
    .base_used_o      (base_used_o)
  );

  always #10 clk_i = ~clk_i;

  function automatic logic [62:0] mod_product(input logic [62:0] x, input logic [62:0] y,
                                              input logic [62:0] m);
    logic [127:0] prod;
    logic [127:0] rem;
    prod = {65'd0, x} * {65'd0, y};
    rem  = prod % {65'd0, m};
    return rem[62:0];
  endfunction

  function automatic logic [62:0] mod_power(input logic [62:0] b, input logic [62:0] e,
                                            input logic [62:0] m);
    logic [62:0] acc;
    logic [62:0] sq;
    logic [62:0] rest;
    acc  = 63'd1;
    sq   = b % m;
    rest = e;
    while (rest != 0) begin
      if (rest[0]) acc = mod_product(acc, sq, m);
      sq   = mod_product(sq, sq, m);
      rest = rest >> 1;
    end
    return acc;
  endfunction

  function automatic verdict_t judge_candidate(input logic [62:0] n, input logic [62:0] a);
    verdict_t    v;
    logic [62:0] d;
    logic [62:0] cur;
    logic [62:0] prev;
    int          twos;
    bit          composite;
    v.cand     = n;
    v.base     = a;
    v.prime    = 1'b0;
    v.via_base = 1'b0;
    if (n < 2) return v;
    if (n == 2) begin
      v.prime = 1'b1;
      return v;
    end
    if (!n[0]) return v;
    d         = n - 1;
    twos      = 0;
    composite = 1'b0;
    while (!d[0]) begin
      d    = d >> 1;
      twos = twos + 1;
    end
    cur  = mod_power(a, d, n);
    prev = cur;
    for (int i = 0; i < twos; i++) begin
      cur = mod_product(cur, cur, n);
      if (cur == 1 && prev != 1 && prev != n - 1) begin
        composite = 1'b1;
        break;
      end
      prev = cur;
    end
    if (cur != 1) composite = 1'b1;
    v.prime    = !composite;
    v.via_base = 1'b1;
    return v;
  endfunction

  function automatic logic [62:0] rand_word();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[62:0];
  endfunction

  function automatic logic [62:0] table_prime(input int idx);
    case (idx)
      0:       return 63'd3;
      1:       return 63'd97;
      2:       return 63'd104729;
      3:       return FERMAT_16;
      4:       return 63'd998244353;
      5:       return 63'd1000000007;
      6:       return 63'd2147483647;
      7:       return 63'd4294967291;
      8:       return MERSENNE_61;
      default: return TOP_PRIME;
    endcase
  endfunction

  task automatic send_item(input logic [62:0] cand, input logic [62:0] base);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid <= 1'b1;
    cand_d   <= cand;
    base_d   <= base;
    do @(posedge clk_i); while (in_stall_o);
    pending_verdicts.push_back(judge_candidate(cand, base));
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic test_trivial_candidates();
    send_item(63'd0, rand_word());
    send_item(63'd1, 63'd1);
    send_item(63'd2, ALL_ONES);
    send_item(63'd4, 63'd3);
    send_item(ALL_ONES - 1, 63'd0);
  endtask

  task automatic test_special_bases();
    send_item(MERSENNE_61, 63'd0);
    send_item(MERSENNE_61, MERSENNE_61);
    send_item(MERSENNE_61, 63'd1);
    send_item(MERSENNE_61, MERSENNE_61 - 1);
    send_item(63'd97, 63'd291);
  endtask

  task automatic test_large_operands();
    send_item(ALL_ONES, ALL_ONES);
    send_item(ALL_ONES, 63'd2);
    send_item(TOP_PRIME, 63'd2);
    send_item(TOP_PRIME, ALL_ONES);
    send_item(63'd4611686018427387905, 63'd3);
  endtask

  task automatic test_pseudoprimes();
    send_item(63'd3, 63'd2);
    send_item(63'd3, 63'd0);
    send_item(63'd561, 63'd2);
    send_item(63'd2047, 63'd2);
    send_item(63'd2047, 63'd3);
    send_item(FERMAT_16, 63'd3);
    send_item(63'd3215031751, 63'd7);
  endtask

  task automatic test_random_traffic(input int count, input int send_pct, input int recv_pct);
    logic [62:0] cand;
    logic [62:0] base;
    int          sel;
    int          len;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    for (int k = 0; k < count; k++) begin
      sel = $urandom_range(0, 99);
      if (sel < 10) begin
        cand = (sel < 4) ? 63'($urandom_range(0, 2)) : rand_word() & ~63'd1;
      end else if (sel < 35) begin
        cand = table_prime($urandom_range(0, 9));
      end else if (sel < 45) begin
        cand = table_prime($urandom_range(0, 6)) * table_prime($urandom_range(0, 6));
      end else begin
        len            = $urandom_range(2, 63);
        cand           = rand_word() >> (63 - len);
        cand[0]        = 1'b1;
        cand[len - 1]  = 1'b1;
      end
      sel = $urandom_range(0, 99);
      if (sel < 8) base = 63'd0;
      else if (sel < 14) base = 63'd1;
      else if (sel < 20) base = cand - 1;
      else if (sel < 24) base = cand;
      else base = rand_word() >> $urandom_range(0, 62);
      send_item(cand, base);
    end
    wait_drained();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
  endtask

  task automatic test_output_backpressure();
    hold_req = 1'b1;
    send_item(63'd6, 63'd5);
    send_item(63'd1, 63'd0);
    send_item(63'd15, 63'd2);
    send_item(63'd2, 63'd7);
    send_item(63'd97, 63'd5);
    send_item(63'd100, 63'd9);
    while (hold_count < HOLD_CYCLES) @(posedge clk_i);
    hold_req = 1'b0;
    wait_drained();
  endtask

  always @(negedge clk_i) begin
    if (hold_req && hold_count < HOLD_CYCLES) begin
      out_stall  <= 1'b1;
      hold_count <= hold_count + 1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
      if (!hold_req) hold_count <= 0;
    end
  end

  always @(posedge clk_i) begin : check_results
    verdict_t want;
    if (rst_ni && out_valid_o && !out_stall) begin
      if (pending_verdicts.size() == 0) begin
        $display("%0t: unexpected result transaction, prime %0b base_used %0b",
                 $time, probable_prime_o, base_used_o);
        mismatch_count++;
      end else begin
        want = pending_verdicts.pop_front();
        if (probable_prime_o !== want.prime) begin
          $display("%0t: n=%0d a=%0d probable_prime expected %0b actual %0b",
                   $time, want.cand, want.base, want.prime, probable_prime_o);
          mismatch_count++;
        end
        if (base_used_o !== want.via_base) begin
          $display("%0t: n=%0d a=%0d base_used expected %0b actual %0b",
                   $time, want.cand, want.base, want.via_base, base_used_o);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    clk_i    = 1'b0;
    rst_ni   = 1'b0;
    in_valid = 1'b0;
    cand_d   = '0;
    base_d   = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_trivial_candidates();
    test_special_bases();
    test_large_operands();
    test_pseudoprimes();
    wait_drained();
    test_output_backpressure();
    test_random_traffic(20, 0, 0);
    test_random_traffic(20, 59, 0);
    test_random_traffic(20, 0, 59);
    test_random_traffic(20, 19, 19);

    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
